### rtl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, controller state encoding and command/status structs.
// ---------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PROD  = 8'b0000_0010,
        ST_SUM   = 8'b0000_0100,
        ST_GINIT = 8'b0000_1000,
        ST_GCD   = 8'b0001_0000,
        ST_DINIT = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word
        logic prod;      // form the cross products
        logic sum;       // combine into numerator and denominator
        logic ginit;     // load the gcd operands
        logic gstep;     // one binary gcd step
        logic dinit;     // load both dividers
        logic dstep;     // one restoring division step on both
        logic outld;     // load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gdone;     // gcd finished
        logic ddone;     // divisions finished
        logic zero;      // zero numerator, compare or bad op; no reduction
    } sts_t;

endpackage
`default_nettype wire

### rtl/rau_ctrl.sv
// ---------------------------------------------------------------------------
// rau_ctrl: sequencing controller
// Steps one item through products, gcd search, division and output.
// ---------------------------------------------------------------------------
`default_nettype none
module rau_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    input  rau_pkg::sts_t       sts,
    output rau_pkg::cmd_t       cmd
);
    rau_pkg::state_t state_reg, state_next;
    logic            ov_reg, ov_next;

    always_comb begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = rau_pkg::ST_PROD;
                end
            end
            rau_pkg::ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = rau_pkg::ST_SUM;
            end
            rau_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = rau_pkg::ST_GINIT;
            end
            rau_pkg::ST_GINIT: begin
                cmd.ginit  = 1'b1;
                state_next = sts.zero ? rau_pkg::ST_OUT : rau_pkg::ST_GCD;
            end
            rau_pkg::ST_GCD: begin
                cmd.gstep = 1'b1;
                if (sts.gdone) begin
                    state_next = rau_pkg::ST_DINIT;
                end
            end
            rau_pkg::ST_DINIT: begin
                cmd.dinit  = 1'b1;
                state_next = rau_pkg::ST_DIV;
            end
            rau_pkg::ST_DIV: begin
                cmd.dstep = 1'b1;
                if (sts.ddone) begin
                    state_next = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_OUT: begin
                if (!ov_reg || out_ready) begin
                    cmd.outld  = 1'b1;
                    ov_next    = 1'b1;
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == rau_pkg::ST_IDLE);
    assign out_valid = ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_outld: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.outld |=> ov_reg) else $error("result not presented");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !out_ready && state_reg != rau_pkg::ST_OUT) |=> ov_reg)
        else $error("result dropped");
endmodule
`default_nettype wire

### rtl/rau_dp.sv
// ---------------------------------------------------------------------------
// rau_dp: arithmetic datapath
// Cross products, binary gcd, two restoring dividers and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module rau_dp #(
    parameter int FRAC_WIDTH = 32
) (
    input  wire                 aclk,
    input  rau_pkg::cmd_t       cmd,
    output rau_pkg::sts_t       sts,
    input  wire  [2:0]          req_type,
    input  wire  [31:0]         a_num,
    input  wire  [30:0]         a_den,
    input  wire  [31:0]         b_num,
    input  wire  [30:0]         b_den,
    output logic [63:0]         res_num,
    output logic [62:0]         res_den,
    output logic                a_less,
    output logic                a_equal,
    output logic                div_zero
);
    localparam int DW  = FRAC_WIDTH - 1;
    localparam int CW  = 6;

    logic [2:0]             op_reg;
    logic signed [31:0]     an_reg, bn_reg, ad_reg, bd_reg;
    logic signed [63:0]     p0_reg, p1_reg, p2_reg;
    logic                   neg_reg, dz_reg, lt_reg, eq_reg, zero_reg;
    logic [63:0]            mn_reg, md_reg;
    logic [63:0]            u_reg, v_reg;
    logic [CW-1:0]          k_reg;
    logic                   gphase_reg;
    logic [63:0]            g_reg;
    logic [63:0]            qn_reg, qd_reg, rn_reg, rd_reg;
    logic [6:0]             dcnt_reg;

    logic signed [31:0]     an_v, bn_v, ad_v, bd_v;
    logic [DW-1:0]          adl, bdl;
    logic signed [63:0]     sn, sd;
    logic [64:0]            trn, trd;

    always_comb begin
        adl  = a_den[DW-1:0];
        bdl  = b_den[DW-1:0];
        an_v = 32'(signed'(a_num[FRAC_WIDTH-1:0]));
        bn_v = 32'(signed'(b_num[FRAC_WIDTH-1:0]));
        ad_v = (adl == '0) ? 32'sd1 : signed'(32'(adl));
        bd_v = (bdl == '0) ? 32'sd1 : signed'(32'(bdl));
    end

    // Signed numerator and denominator before reduction.
    always_comb begin
        sn = 64'sd0;
        sd = 64'sd1;
        case (op_reg)
            rau_pkg::OP_ADD: begin sn = p0_reg + p1_reg; sd = p2_reg; end
            rau_pkg::OP_SUB: begin sn = p0_reg - p1_reg; sd = p2_reg; end
            rau_pkg::OP_MUL: begin sn = p0_reg; sd = p2_reg; end
            rau_pkg::OP_DIV: begin
                if (dz_reg) begin
                    sn = 64'(an_reg); sd = 64'(ad_reg);
                end else begin
                    sn = p0_reg; sd = p1_reg;
                end
            end
            default: begin sn = 64'sd0; sd = 64'sd1; end
        endcase
    end

    assign trn = {rn_reg, qn_reg[63]} - {1'b0, g_reg};
    assign trd = {rd_reg, qd_reg[63]} - {1'b0, g_reg};

    assign sts.zero  = zero_reg;
    assign sts.gdone = gphase_reg && (v_reg == 64'd0);
    assign sts.ddone = (dcnt_reg == 7'd63);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= req_type;
            an_reg <= an_v;
            bn_reg <= bn_v;
            ad_reg <= ad_v;
            bd_reg <= bd_v;
            dz_reg <= (req_type == rau_pkg::OP_DIV) && (bn_v == 32'sd0);
        end
        if (cmd.prod) begin
            // Three 32x32 products (two for multiply), paired by operation.
            case (op_reg)
                rau_pkg::OP_MUL: begin
                    p0_reg <= an_reg * bn_reg;
                    p1_reg <= 64'sd0;
                end
                rau_pkg::OP_DIV: begin
                    p0_reg <= an_reg * bd_reg;
                    p1_reg <= ad_reg * bn_reg;
                end
                default: begin
                    p0_reg <= an_reg * bd_reg;
                    p1_reg <= bn_reg * ad_reg;
                end
            endcase
            p2_reg <= ad_reg * bd_reg;
        end
        if (cmd.sum) begin
            neg_reg  <= (sn < 0) != (sd < 0);
            mn_reg   <= (sn < 0) ? 64'(-sn) : 64'(sn);
            md_reg   <= (sd < 0) ? 64'(-sd) : 64'(sd);
            zero_reg <= (sn == 64'sd0) || (op_reg > rau_pkg::OP_DIV);
            lt_reg   <= (op_reg == rau_pkg::OP_CMP) && (p0_reg < p1_reg);
            eq_reg   <= (op_reg == rau_pkg::OP_CMP) && (p0_reg == p1_reg);
        end
        if (cmd.ginit) begin
            u_reg      <= mn_reg;
            v_reg      <= md_reg;
            k_reg      <= '0;
            gphase_reg <= 1'b0;
        end
        if (cmd.gstep) begin
            // Phase 0 strips common twos, then u odd; phase 1 is the main loop.
            if (!gphase_reg) begin
                if (((u_reg | v_reg) & 64'd1) == 64'd0) begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end else if (!u_reg[0]) begin
                    u_reg <= u_reg >> 1;
                end else begin
                    gphase_reg <= 1'b1;
                end
            end else if (v_reg != 64'd0) begin
                if (!v_reg[0]) begin
                    v_reg <= v_reg >> 1;
                end else if (u_reg > v_reg) begin
                    u_reg <= v_reg;
                    v_reg <= u_reg - v_reg;
                end else begin
                    v_reg <= v_reg - u_reg;
                end
            end
        end
        if (cmd.dinit) begin
            g_reg    <= u_reg << k_reg;
            qn_reg   <= mn_reg;
            qd_reg   <= md_reg;
            rn_reg   <= '0;
            rd_reg   <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.dstep) begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!trn[64]) begin
                rn_reg <= trn[63:0];
                qn_reg <= {qn_reg[62:0], 1'b1};
            end else begin
                rn_reg <= {rn_reg[62:0], qn_reg[63]};
                qn_reg <= {qn_reg[62:0], 1'b0};
            end
            if (!trd[64]) begin
                rd_reg <= trd[63:0];
                qd_reg <= {qd_reg[62:0], 1'b1};
            end else begin
                rd_reg <= {rd_reg[62:0], qd_reg[63]};
                qd_reg <= {qd_reg[62:0], 1'b0};
            end
        end
        if (cmd.outld) begin
            if (zero_reg) begin
                res_num <= 64'd0;
                res_den <= 63'd1;
            end else begin
                res_num <= neg_reg ? (64'd0 - qn_reg) : qn_reg;
                res_den <= qd_reg[62:0];
            end
            a_less   <= lt_reg;
            a_equal  <= eq_reg;
            div_zero <= dz_reg;
        end
    end
endmodule
`default_nettype wire

### rtl/rational_arith_unit_top.sv
// ---------------------------------------------------------------------------
// rational_arith_unit_top: exact fraction arithmetic with gcd reduction
// Adds, subtracts, multiplies, divides or compares two fractions.
// ---------------------------------------------------------------------------
// Channel | Direction | Word contents (lowest bit first)
// s_axis  | in        | tdata: req_type[2:0], a_num, a_den, b_num, b_den (136 bits)
// m_axis  | out       | tdata: res_num, res_den, a_less, a_equal, div_zero (136 bits)
//
// One word is processed at a time. After acceptance the controller steps through
// products, sum and gcd set-up, then the binary gcd loop, loading the dividers,
// the two 64-bit restoring dividers and the output load. A zero result, a
// compare or an unknown operation skips gcd and division. Reset is synchronous
// and active low; it clears the controller and the output valid. A stalled
// result sits in the output register and the next word is accepted meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none
module rational_arith_unit_top #(
    parameter int FRAC_WIDTH = 32
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98], zero fill
    input  wire  [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // res_num[63:0], res_den[126:64], a_less[127], a_equal[128], div_zero[129], zero fill
    output logic [135:0] m_axis_tdata
);
    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;
    logic [63:0]   res_num;
    logic [62:0]   res_den;
    logic          a_less, a_equal, div_zero;

    // The controller sequences the word through the datapath.
    rau_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds operands, gcd and dividers and the output register.
    rau_dp #(.FRAC_WIDTH(FRAC_WIDTH)) u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .sts      (sts),
        .req_type (s_axis_tdata[2:0]),
        .a_num    (s_axis_tdata[34:3]),
        .a_den    (s_axis_tdata[65:35]),
        .b_num    (s_axis_tdata[97:66]),
        .b_den    (s_axis_tdata[128:98]),
        .res_num  (res_num),
        .res_den  (res_den),
        .a_less   (a_less),
        .a_equal  (a_equal),
        .div_zero (div_zero)
    );

    assign m_axis_tdata = {6'd0, div_zero, a_equal, a_less, res_den, res_num};
endmodule
`default_nettype wire

### dv/rational_arith_unit_top_tb.sv
// ---------------------------------------------------------------------------
// rational_arith_unit_top_tb: self-checking bench for the fraction unit
// Drives operation words through the input stream, predicts each result with
// an independent exact-arithmetic model and compares every returned word
// field by field, under several phases of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module rational_arith_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = 32;
    localparam longint unsigned LIMIT = 64'd2_000_000;
    localparam int N_RANDOM = 430;
    // Operation codes outside the defined set.
    localparam logic [2:0] OP_BAD5 = 3'd5;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    // One result word as the block packs it, lowest field last.
    typedef struct packed {
        logic        dz;
        logic        eq;
        logic        lt;
        logic [62:0] den;
        logic [63:0] num;
    } fraction_res_t;

    // One input word.
    typedef struct {
        logic [2:0]  op;
        logic [31:0] an;
        logic [30:0] ad;
        logic [31:0] bn;
        logic [30:0] bd;
    } fraction_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;

    always #6 aclk = ~aclk;

    rational_arith_unit_top #(.FRAC_WIDTH(FW)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    fraction_res_t expected_q[$];
    int unsigned mismatches = 0;
    longint unsigned cycle_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;

    // Directed words and, where obvious, their results.
    fraction_req_t dir_req[$];
    fraction_res_t dir_res[$];
    bit dir_known[$];

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] gcd64(input logic [63:0] u, input logic [63:0] v);
        int k;
        logic [63:0] t;
        k = 0;
        if (u == 0) return v;
        if (v == 0) return u;
        while (((u | v) & 1) == 0) begin
            u >>= 1; v >>= 1; k++;
        end
        while ((u & 1) == 0) u >>= 1;
        while (v != 0) begin
            while ((v & 1) == 0) v >>= 1;
            if (u > v) begin
                t = u; u = v; v = t;
            end
            v -= u;
        end
        return u << k;
    endfunction

    // Reduced n/d with the sign carried by the numerator.
    function automatic fraction_res_t lowest_terms(input longint n, input longint d);
        fraction_res_t r;
        logic [63:0] mn, md, g;
        r = '0;
        mn = mag64(n);
        md = mag64(d);
        if (mn == 0) begin
            r.den = 63'd1;
            return r;
        end
        g = gcd64(mn, md);
        mn = mn / g;
        md = md / g;
        r.num = ((n < 0) != (d < 0)) ? -mn : mn;
        r.den = md[62:0];
        return r;
    endfunction

    function automatic fraction_res_t predict_fraction(input fraction_req_t q);
        fraction_res_t r;
        longint an, ad, bn, bd, l, rr;
        r = '0;
        r.den = 63'd1;
        an = longint'($signed(q.an));
        bn = longint'($signed(q.bn));
        ad = (q.ad == 0) ? 1 : longint'({33'd0, q.ad});
        bd = (q.bd == 0) ? 1 : longint'({33'd0, q.bd});
        case (q.op)
            rau_pkg::OP_ADD: r = lowest_terms(an * bd + bn * ad, ad * bd);
            rau_pkg::OP_SUB: r = lowest_terms(an * bd - bn * ad, ad * bd);
            rau_pkg::OP_MUL: r = lowest_terms(an * bn, ad * bd);
            rau_pkg::OP_DIV: begin
                if (bn == 0) begin
                    r = lowest_terms(an, ad);
                    r.dz = 1'b1;
                end else begin
                    r = lowest_terms(an * bd, ad * bn);
                end
            end
            rau_pkg::OP_CMP: begin
                l = an * bd;
                rr = bn * ad;
                r.lt = l < rr;
                r.eq = l == rr;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic fraction_res_t lit(input longint n, input longint d,
                                          input bit lt, input bit eq, input bit dz);
        fraction_res_t r;
        r.num = 64'(n);
        r.den = 63'(d);
        r.lt = lt;
        r.eq = eq;
        r.dz = dz;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [31:0] an, input logic [30:0] ad,
                           input logic [31:0] bn, input logic [30:0] bd,
                           input bit known, input fraction_res_t r);
        fraction_req_t q;
        q.op = op; q.an = an; q.ad = ad; q.bn = bn; q.bd = bd;
        dir_req.push_back(q);
        dir_res.push_back(r);
        dir_known.push_back(known);
    endtask

    // Each accepted word is offered once; valid stays high across back-to-back words.
    task automatic send_word(input fraction_req_t q, input fraction_res_t r);
        bit idle;
        idle = ($urandom_range(99) < send_idle_pct);
        if (idle) begin
            s_axis_tvalid <= 1'b0;
            while (idle) begin
                @(posedge aclk);
                idle = ($urandom_range(99) < send_idle_pct);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, q.bd, q.bn, q.ad, q.an, q.op};
        do @(posedge aclk); while (!s_axis_tready);
        expected_q.push_back(r);
    endtask

    function automatic logic [31:0] rand_num();
        case ($urandom_range(5))
            0: return 32'($urandom_range(20)) - 32'd10;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0001;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(5))
            0: return 31'($urandom_range(12));
            1: return 31'h7FFF_FFFF;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic run_random(input int count);
        fraction_req_t q;
        repeat (count) begin
            q.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(4));
            q.an = rand_num();
            q.ad = rand_den();
            q.bn = ($urandom_range(9) == 0) ? 32'd0 : rand_num();
            q.bd = rand_den();
            // Equal fractions now and then, so compare reports equality.
            if ($urandom_range(7) == 0) begin
                q.bn = q.an; q.bd = q.ad;
            end
            send_word(q, predict_fraction(q));
        end
    endtask

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker.
    always @(posedge aclk) begin
        fraction_res_t got, exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[129:0];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: num %h/%h den %h/%h lt %b/%b eq %b/%b dz %b/%b",
                                 got.num, exp_r.num, got.den, exp_r.den, got.lt, exp_r.lt,
                                 got.eq, exp_r.eq, got.dz, exp_r.dz);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("FAIL rational_arith_unit_top");
            $finish;
        end
    end

    initial begin
        int i, drain;
        add_row(rau_pkg::OP_ADD, 32'd0, 31'd1, 32'd0, 31'd1, 1'b1, lit(0, 1, 0, 0, 0));
        add_row(rau_pkg::OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 1'b1, lit(5, 6, 0, 0, 0));
        add_row(rau_pkg::OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2, 1'b1, lit(0, 1, 0, 0, 0));
        add_row(rau_pkg::OP_SUB, 32'd1, 31'd3, 32'd1, 31'd2, 1'b1, lit(-1, 6, 0, 0, 0));
        add_row(rau_pkg::OP_MUL, 32'd2, 31'd3, 32'd3, 31'd4, 1'b1, lit(1, 2, 0, 0, 0));
        add_row(rau_pkg::OP_DIV, 32'd1, 31'd2, 32'hFFFF_FFFF, 31'd4, 1'b1,
                lit(-2, 1, 0, 0, 0));
        // Divide by a zero fraction returns a, reduced.
        add_row(rau_pkg::OP_DIV, 32'd6, 31'd4, 32'd0, 31'd7, 1'b1, lit(3, 2, 0, 0, 1));
        add_row(rau_pkg::OP_CMP, 32'd1, 31'd2, 32'd2, 31'd4, 1'b1, lit(0, 1, 0, 1, 0));
        add_row(rau_pkg::OP_CMP, 32'hFFFF_FFFF, 31'd2, 32'd1, 31'd3, 1'b1,
                lit(0, 1, 1, 0, 0));
        add_row(rau_pkg::OP_CMP, 32'd1, 31'd2, 32'd1, 31'd3, 1'b1, lit(0, 1, 0, 0, 0));
        // Zero denominators read as one.
        add_row(rau_pkg::OP_ADD, 32'd3, 31'd0, 32'd4, 31'd0, 1'b1, lit(7, 1, 0, 0, 0));
        // Unknown operations give 0/1 and no flags.
        add_row(OP_BAD5, 32'd9, 31'd2, 32'd9, 31'd2, 1'b1, lit(0, 1, 0, 0, 0));
        add_row(OP_BAD7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                1'b1, lit(0, 1, 0, 0, 0));
        // Extremes and unreduced operands go to the predictor.
        add_row(rau_pkg::OP_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFE,
                1'b0, '0);
        add_row(rau_pkg::OP_SUB, 32'h8000_0001, 31'd1, 32'h7FFF_FFFF, 31'd1, 1'b0, '0);
        add_row(rau_pkg::OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1, 1'b0, '0);
        add_row(rau_pkg::OP_MUL, 32'h8000_0001, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFD,
                1'b0, '0);
        add_row(rau_pkg::OP_DIV, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'h7FFF_FFFF,
                1'b0, '0);
        add_row(rau_pkg::OP_DIV, 32'h7FFF_FFFF, 31'h5555_5555, 32'h8000_0001, 31'h2AAA_AAAA,
                1'b0, '0);
        add_row(rau_pkg::OP_CMP, 32'h8000_0000, 31'd1, 32'h8000_0001, 31'd1, 1'b0, '0);
        add_row(rau_pkg::OP_CMP, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd1, 31'd1, 1'b0, '0);
        add_row(rau_pkg::OP_ADD, 32'd48, 31'd36, 32'hFFFF_FFE8, 31'd18, 1'b0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < dir_req.size(); i++)
            send_word(dir_req[i], dir_known[i] ? dir_res[i] : predict_fraction(dir_req[i]));

        // Long receiver hold-off while the sender keeps offering words.
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge aclk);
                hold_off = 1'b0;
            end
            run_random(10);
        join

        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(N_RANDOM / 4);
        send_idle_pct = 72; recv_stall_pct = 0;  run_random(N_RANDOM / 4);
        send_idle_pct = 0;  recv_stall_pct = 72; run_random(N_RANDOM / 4);
        send_idle_pct = 15; recv_stall_pct = 15; run_random(N_RANDOM / 4);
        s_axis_tvalid <= 1'b0;

        recv_stall_pct = 0;
        while (expected_q.size() != 0) @(posedge aclk);
        drain = 0;
        while (drain < 300) begin
            @(posedge aclk);
            drain++;
        end

        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS rational_arith_unit_top");
        else
            $display("FAIL rational_arith_unit_top");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arith_unit_top.sv
dv/rational_arith_unit_top_tb.sv
